>>> rtl/core/spcd_pkg.sv
// Shared constants, types and helpers for the switch pulse combination detector.
package spcd_pkg;

    localparam int TIME_W  = 32;
    localparam int CNT_W   = 4;
    localparam int KEY_W   = 4;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [KEY_W-1:0] ARM_PULSES_RST    = KEY_W'(3);
    localparam logic [KEY_W-1:0] DISARM_PULSES_RST = KEY_W'(2);
    localparam logic [MS_W-1:0]  ENTRY_TIMEOUT_RST = MS_W'(4000);
    localparam logic [MS_W-1:0]  DEBOUNCE_RST      = MS_W'(500);

    typedef enum logic [CFG_A_W-1:0] {
        CFG_ARM_PULSES    = 2'd0,
        CFG_DISARM_PULSES = 2'd1,
        CFG_ENTRY_TIMEOUT = 2'd2,
        CFG_DEBOUNCE      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        COMBO_NONE   = 2'd0,
        COMBO_ARM    = 2'd1,
        COMBO_DISARM = 2'd2
    } combo_t;

    typedef enum logic [1:0] {
        POS_RIGHT   = 2'd0,
        POS_LEFT    = 2'd1,
        POS_NEUTRAL = 2'd2
    } pos_t;

    typedef struct packed {
        logic [KEY_W-1:0] arm_pulses;
        logic [KEY_W-1:0] disarm_pulses;
        logic [MS_W-1:0]  entry_timeout_ms;
        logic [MS_W-1:0]  debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] pulse_time;
        logic              take_stamp;
        logic [TIME_W-1:0] success_time;
    } side_t;

    localparam side_t SIDE_RST = '{
        count: '0, start_time: '0, pulse_time: '0, take_stamp: 1'b1, success_time: '0
    };

    // Wrapping difference now - then compared against a millisecond limit.
    function automatic logic gap_exceeds(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] then_t,
                                         input logic [MS_W-1:0]   lim);
        logic [TIME_W-1:0] diff;
        diff = now - then_t;
        return diff > {{(TIME_W-MS_W){1'b0}}, lim};
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
    endfunction

endpackage

>>> rtl/core/spcd_cfg.sv
// Configuration register bank with its reset values.
module spcd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [spcd_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [spcd_pkg::CFG_W-1:0]     cfg_wdata,
    output spcd_pkg::cfg_t                 cfg
);
    import spcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ARM_PULSES:    cfg_next.arm_pulses       = cfg_wdata[KEY_W-1:0];
                CFG_DISARM_PULSES: cfg_next.disarm_pulses    = cfg_wdata[KEY_W-1:0];
                CFG_ENTRY_TIMEOUT: cfg_next.entry_timeout_ms = cfg_wdata[MS_W-1:0];
                CFG_DEBOUNCE:      cfg_next.debounce_ms      = cfg_wdata[MS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{arm_pulses: ARM_PULSES_RST, disarm_pulses: DISARM_PULSES_RST,
                         entry_timeout_ms: ENTRY_TIMEOUT_RST, debounce_ms: DEBOUNCE_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/spcd_step.sv
// Combinational poll step: both side updates, success and timeout checks.
module spcd_step (
    input  spcd_pkg::cfg_t                cfg,
    input  spcd_pkg::side_t               rs_cur,
    input  spcd_pkg::side_t               ls_cur,
    input  logic [spcd_pkg::TIME_W-1:0]   now,
    input  logic                          right_low,
    input  logic                          left_low,
    output spcd_pkg::side_t               rs_new,
    output spcd_pkg::side_t               ls_new,
    output spcd_pkg::combo_t              combo,
    output spcd_pkg::pos_t                pos
);
    import spcd_pkg::*;

    side_t rs;
    side_t ls;
    logic  r_act;
    logic  l_act;
    logic  r_gap;
    logic  l_gap;
    combo_t res;

    // A fresh stamp makes the pulse gap zero, so it never counts on that poll.
    assign r_act = right_low && gap_exceeds(now, rs_cur.success_time, cfg.debounce_ms);
    assign l_act = left_low  && gap_exceeds(now, ls_cur.success_time, cfg.debounce_ms);
    assign r_gap = !rs_cur.take_stamp && gap_exceeds(now, rs_cur.pulse_time, cfg.debounce_ms);
    assign l_gap = !ls_cur.take_stamp && gap_exceeds(now, ls_cur.pulse_time, cfg.debounce_ms);

    always_comb begin
        rs  = rs_cur;
        ls  = ls_cur;
        res = COMBO_NONE;

        if (r_act) begin
            if (rs.take_stamp) begin
                rs.take_stamp = 1'b0;
                rs.pulse_time = now;
            end
            if (rs.count == '0) begin
                ls.count      = '0;
                ls.take_stamp = 1'b1;
                rs.start_time = now;
                rs.count      = CNT_W'(1);
            end else if (r_gap) begin
                rs.count      = bump(rs.count);
                rs.take_stamp = 1'b1;
            end
        end

        if (rs.count == cfg.arm_pulses) begin
            rs.count        = '0;
            rs.take_stamp   = 1'b1;
            ls.count        = '0;
            ls.take_stamp   = 1'b1;
            rs.success_time = now;
            res             = COMBO_ARM;
        end else begin
            if (rs.count != '0 && gap_exceeds(now, rs.start_time, cfg.entry_timeout_ms)) begin
                rs.count      = '0;
                rs.take_stamp = 1'b1;
                ls.count      = '0;
                ls.take_stamp = 1'b1;
            end

            // Left side reads the left state as the right side left it.
            if (l_act) begin
                if (ls.take_stamp) begin
                    ls.take_stamp = 1'b0;
                    ls.pulse_time = now;
                end
                if (ls.count == '0) begin
                    rs.count      = '0;
                    rs.take_stamp = 1'b1;
                    ls.start_time = now;
                    ls.count      = CNT_W'(1);
                end else if (l_gap && !ls.take_stamp && ls_cur.take_stamp == 1'b0) begin
                    ls.count      = bump(ls.count);
                    ls.take_stamp = 1'b1;
                end
            end

            if (ls.count == cfg.disarm_pulses) begin
                ls.count        = '0;
                ls.take_stamp   = 1'b1;
                rs.count        = '0;
                rs.take_stamp   = 1'b1;
                ls.success_time = now;
                res             = COMBO_DISARM;
            end else if (ls.count != '0
                         && gap_exceeds(now, ls.start_time, cfg.entry_timeout_ms)) begin
                ls.count      = '0;
                ls.take_stamp = 1'b1;
                rs.count      = '0;
                rs.take_stamp = 1'b1;
            end
        end
    end

    assign rs_new = rs;
    assign ls_new = ls;
    assign combo  = res;
    assign pos    = right_low ? POS_RIGHT : (left_low ? POS_LEFT : POS_NEUTRAL);

endmodule

>>> rtl/core/switch_pulse_combination_detector.sv
// Top level: config bank, input register, state registers, step logic and result register.
//
// Each input beat is one poll of a three-position switch: the free-running
// millisecond time and the two active-low contacts (already inverted, so 1
// means the contact is closed). Each accepted beat yields exactly one result
// beat carrying the combination outcome (none, arm, disarm) and the switch
// position, in the order the polls arrived.
// An accepted beat is held in the input register, worked through the step
// logic and registered into the result register that drives m_tvalid.
// Throughput: one beat per cycle while the receiver keeps m_tready high; the
// state registers update from the step logic on each advance.
// When the receiver stalls, the result beat holds in the output register and
// one further poll waits in the input register; s_tready then drops.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults (arm 3, disarm 2, timeout 4000 ms, debounce 500 ms),
// clears both pulse counts and all times, and sets both take-stamp flags.
// Configuration writes land one per cycle on cfg_we, and should only be made
// while no poll is in flight.
module switch_pulse_combination_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [32] right_low, [33] left_low, [39:34] zero
    input  logic [spcd_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] combo_result, [3:2] switch_position, [7:4] zero
    output logic [spcd_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [spcd_pkg::CFG_A_W-1:0]        cfg_index,
    input  logic [spcd_pkg::CFG_W-1:0]          cfg_wdata
);
    import spcd_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_right_reg;
    logic              in_left_reg;
    side_t             rs_reg;
    side_t             ls_reg;
    side_t             rs_next;
    side_t             ls_next;
    combo_t            combo;
    pos_t              pos;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              advance;
    logic              s_accept;

    spcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spcd_step u_step (
        .cfg       (cfg),
        .rs_cur    (rs_reg),
        .ls_cur    (ls_reg),
        .now       (in_now_reg),
        .right_low (in_right_reg),
        .left_low  (in_left_reg),
        .rs_new    (rs_next),
        .ls_new    (ls_next),
        .combo     (combo),
        .pos       (pos)
    );

    // Advance the held poll once the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rs_reg        <= SIDE_RST;
            ls_reg        <= SIDE_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                rs_reg        <= rs_next;
                ls_reg        <= ls_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_now_reg   <= s_tdata[TIME_W-1:0];
            in_right_reg <= s_tdata[TIME_W];
            in_left_reg  <= s_tdata[TIME_W+1];
        end
        if (advance) begin
            out_data_reg <= {4'b0000, pos, combo};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/spcd_checker.sv
// Port-level checker for the switch pulse combination detector, with its bind.
module spcd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [spcd_pkg::M_DATA_W-1:0]       m_tdata
);
    import spcd_pkg::*;

    // Drop any result beat on reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat visible after reset");

    // Hold a stalled result beat.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A draining receiver always frees the input side.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3
                     && m_tdata[7:4] == 4'd0)
        else $error("result beat carries an unused code");

endmodule

bind switch_pulse_combination_detector spcd_checker u_spcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
